>>> src/shbcc_pkg.sv
// ----------------------------------------------------------------------------
// shbcc_pkg
// Shared types and constants for the string hash bucket collision counter.
// ----------------------------------------------------------------------------
package shbcc_pkg;

  localparam int MAX_BUCKETS      = 32768;
  localparam int HASH_W           = 32;
  localparam int KEY_W            = 8;
  localparam int SIZE_W           = 16;
  localparam int IDX_W            = $clog2(MAX_BUCKETS);
  localparam int OUT_IDX_W        = 15;
  localparam int COUNT_W          = 32;
  localparam int HASH_MULT        = 31;
  localparam int TABLE_SIZE_RESET = 20011;

  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = HASH_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_ACCEPT,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

>>> src/shbcc_key_if.sv
// ----------------------------------------------------------------------------
// shbcc_key_if
// Key byte channel: one word carries one key byte and its framing flags.
// ----------------------------------------------------------------------------
interface shbcc_key_if;
  logic                        valid;
  logic                        ready;
  logic [shbcc_pkg::KEY_W-1:0] key_byte;
  logic                        byte_present;
  logic                        last_of_key;

  modport source (output valid, output key_byte, output byte_present,
                  output last_of_key, input ready);
  modport sink   (input valid, input key_byte, input byte_present,
                  input last_of_key, output ready);
endinterface

>>> src/shbcc_result_if.sv
// ----------------------------------------------------------------------------
// shbcc_result_if
// Result channel: one word per finished key.
// ----------------------------------------------------------------------------
interface shbcc_result_if;
  logic                            valid;
  logic                            ready;
  logic [shbcc_pkg::OUT_IDX_W-1:0] bucket_index;
  logic                            collided;
  logic [shbcc_pkg::COUNT_W-1:0]   collision_count;

  modport source (output valid, output bucket_index, output collided,
                  output collision_count, input ready);
  modport sink   (input valid, input bucket_index, input collided,
                  input collision_count, output ready);
endinterface

>>> src/shbcc_cfg_if.sv
// ----------------------------------------------------------------------------
// shbcc_cfg_if
// Configuration write channel for the table size register.
// ----------------------------------------------------------------------------
interface shbcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [shbcc_pkg::SIZE_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

>>> src/shbcc_mod_unit.sv
// ----------------------------------------------------------------------------
// shbcc_mod_unit
// Iterative remainder unit: hash modulo divisor, four bits per cycle.
// ----------------------------------------------------------------------------
module shbcc_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [shbcc_pkg::HASH_W-1:0]    dividend,
  input  logic [shbcc_pkg::SIZE_W-1:0]    divisor,
  output logic                            done,
  output logic [shbcc_pkg::IDX_W-1:0]     remainder
);
  import shbcc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [HASH_W-1:0]    shift;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    dvs;

  logic [HASH_W-1:0]    shift_next;
  logic [SIZE_W-1:0]    rem_next;
  logic [SIZE_W:0]      trial;

  always_comb begin
    rem_next   = rem;
    shift_next = shift;
    trial      = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial = {rem_next, shift_next[HASH_W-1]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
      end
      rem_next   = trial[SIZE_W-1:0];
      shift_next = {shift_next[HASH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shift <= shift_next;
      rem   <= rem_next;
    end
  end

  assign remainder = rem[IDX_W-1:0];

endmodule

>>> src/string_hash_bucket_collision_counter_core.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_collision_counter_core
// Base-31 string hash with bucket occupancy map and collision counter.
// ----------------------------------------------------------------------------
// A word without the key end leaves the key channel ready; the next is taken at once.
// A word that ends a key goes to its result word through the start, the remainder
// unit (4 bits per cycle), one memory read and one read-modify-write of the
// occupancy memory, which waits while an earlier result word is not taken.
// Reset starts a clearing pass over the 32768-entry occupancy memory; key words
// wait for it, configuration writes are taken as ever.
module string_hash_bucket_collision_counter_core (
  input  logic     clk,
  input  logic     rst,
  shbcc_key_if.sink      key,
  shbcc_result_if.source result,
  shbcc_cfg_if.sink      cfg
);
  import shbcc_pkg::*;

  state_t state, state_next;

  logic [SIZE_W-1:0]  table_size;
  logic [SIZE_W-1:0]  eff_size;
  logic [HASH_W-1:0]  hash;
  logic [HASH_W-1:0]  hash_upd;
  logic [HASH_W-1:0]  hash_in;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   idx;
  logic [COUNT_W-1:0] count;

  logic               key_acc;
  logic               div_start;
  logic               div_done;
  logic [IDX_W-1:0]   div_rem;

  logic               mem [MAX_BUCKETS];
  logic               mem_q;
  logic               mem_rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic               mem_wdata;
  logic               update;

  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_index;
  logic                 out_collided;
  logic [COUNT_W-1:0]   out_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(TABLE_SIZE_RESET);
    end else if (cfg.valid) begin
      table_size <= cfg.table_size;
    end
  end

  always_comb begin
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (table_size > SIZE_W'(MAX_BUCKETS)) begin
      eff_size = SIZE_W'(MAX_BUCKETS);
    end else begin
      eff_size = table_size;
    end
  end

  assign key.ready = (state == ST_ACCEPT);
  assign key_acc   = key.valid && key.ready;
  assign hash_upd  = HASH_W'(hash * HASH_W'(HASH_MULT))
                   + {{(HASH_W-KEY_W){key.key_byte[KEY_W-1]}}, key.key_byte};
  assign hash_in   = key.byte_present ? hash_upd : hash;
  assign div_start = key_acc && key.last_of_key;
  assign update    = (state == ST_UPDATE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (key_acc) begin
      hash <= key.last_of_key ? '0 : hash_in;
    end
  end

  shbcc_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hash_in),
    .divisor   (eff_size),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      idx <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    mem_rd_en  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 1'b0;
        if (clr_addr == '1) begin
          state_next = ST_ACCEPT;
        end
      end
      ST_ACCEPT: begin
        if (div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_rd_en  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (update) begin
          mem_we     = 1'b1;
          state_next = ST_ACCEPT;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (update) begin
        out_valid <= 1'b1;
        if (mem_q && (count != '1)) begin
          count <= count + 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_index    <= OUT_IDX_W'(idx);
      out_collided <= mem_q;
      out_count    <= (mem_q && (count != '1)) ? count + 1'b1 : count;
    end
  end

  assign result.valid           = out_valid;
  assign result.bucket_index    = out_index;
  assign result.collided        = out_collided;
  assign result.collision_count = out_count;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("remainder unit finished outside the divide state");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ({1'b0, idx} < eff_size))
    else $error("bucket index not below the table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1))
    else $error("collision total moved by other than one");

  a_collided_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_collided) |-> (out_count != '0))
    else $error("collision reported with a zero total");
`endif

endmodule
